// File: design/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// shared types and constants of the led pattern sequencer
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int LED_COUNT      = 8;
    localparam int LED_W          = LED_COUNT;
    localparam int POS_W          = 3;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int DWELL_BITS_DEF = 16;

    localparam logic [CFG_W-1:0] DWELL_RESET = 16'd150;
    localparam logic [LED_W-1:0] PAIR_BITS   = 8'h03;

    // highest lower-led position of the ping-pong pair
    localparam logic [POS_W-1:0] PAIR_POS_MAX = POS_W'(LED_COUNT - 2);
    localparam logic [POS_W-1:0] LED_TOP      = POS_W'(LED_COUNT - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_PINGPONG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_WAVE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_EXPLODE  = 2'd2;

    typedef enum logic [1:0] {
        PH_WAVE_UP   = 2'd0,
        PH_WAVE_DOWN = 2'd1,
        PH_EXPLODE   = 2'd2,
        PH_COLLAPSE  = 2'd3
    } t_wave_phase;

    typedef struct packed {
        logic [CFG_W-1:0] dwell_pingpong;
        logic [CFG_W-1:0] dwell_wave;
        logic [CFG_W-1:0] dwell_explode;
    } t_cfg;

endpackage

// File: design/lps_cfg_regs.sv
// ----------------------------------------------------------------------------
// lps_cfg_regs
// dwell configuration registers, written through a plain write port
// ----------------------------------------------------------------------------
module lps_cfg_regs
    import lps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DWELL_PINGPONG: n_cfg.dwell_pingpong = i_cfg_wdata;
                CFG_DWELL_WAVE:     n_cfg.dwell_wave     = i_cfg_wdata;
                CFG_DWELL_EXPLODE:  n_cfg.dwell_explode  = i_cfg_wdata;
                default:            n_cfg = r_cfg;  // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dwell_pingpong <= DWELL_RESET;
            r_cfg.dwell_wave     <= DWELL_RESET;
            r_cfg.dwell_explode  <= DWELL_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/lps_core.sv
// ----------------------------------------------------------------------------
// lps_core
// sequence state, pattern select and dwell counter, one tick per accept
// ----------------------------------------------------------------------------
module lps_core
    import lps_pkg::*;
#(
    parameter int DWELL_BITS = DWELL_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_level,
    input  t_cfg             i_cfg,
    output logic [LED_W-1:0] o_pattern
);

    localparam int CW = ((DWELL_BITS > CFG_W) ? DWELL_BITS : CFG_W) + 1;
    localparam logic [CW-1:0] DWELL_CAP = {{(CW-1){1'b0}}, 1'b1} << DWELL_BITS;

    logic                  r_seen;
    logic                  r_last;
    logic [POS_W-1:0]      r_pair_pos;
    logic                  r_pair_rising;
    t_wave_phase           r_phase;
    logic [POS_W-1:0]      r_wave_idx;
    logic [DWELL_BITS-1:0] r_cnt;

    logic [POS_W-1:0]      n_pair_pos;
    logic                  n_pair_rising;
    t_wave_phase           n_phase;
    logic [POS_W-1:0]      n_wave_idx;
    logic [DWELL_BITS-1:0] n_cnt;

    // state as seen by this tick, after a possible restart
    logic                  restart;
    logic [POS_W-1:0]      pos;
    logic                  rising;
    t_wave_phase           phase;
    logic [POS_W-1:0]      idx;
    logic [DWELL_BITS-1:0] cnt;
    logic [1:0]            k;
    logic [CFG_W-1:0]      dwell_sel;
    logic [CW-1:0]         dwell_raw;
    logic [CW-1:0]         dwell_eff;
    logic [CW-1:0]         cnt_inc;
    logic                  advance;

    always_comb begin
        restart = !r_seen || (i_level != r_last);
        pos     = restart ? '0 : r_pair_pos;
        rising  = restart ? 1'b1 : r_pair_rising;
        phase   = restart ? PH_WAVE_UP : r_phase;
        idx     = restart ? '0 : r_wave_idx;
        cnt     = restart ? '0 : r_cnt;
        k       = idx[1:0];

        if (!i_level) begin
            o_pattern = PAIR_BITS << pos;
            dwell_sel = i_cfg.dwell_pingpong;
        end else if (phase == PH_WAVE_UP || phase == PH_WAVE_DOWN) begin
            o_pattern = {{(LED_W-1){1'b0}}, 1'b1} << idx;
            dwell_sel = i_cfg.dwell_wave;
        end else begin
            o_pattern = ({{(LED_W-1){1'b0}}, 1'b1} << (2'd3 - k))
                      | ({{(LED_W-1){1'b0}}, 1'b1} << ({1'b0, k} + 3'd4));
            dwell_sel = i_cfg.dwell_explode;
        end

        // zero acts as one, anything past the counter range is capped
        dwell_raw = {{(CW-CFG_W){1'b0}}, dwell_sel};
        if (dwell_raw == '0) begin
            dwell_eff = {{(CW-1){1'b0}}, 1'b1};
        end else if (dwell_raw > DWELL_CAP) begin
            dwell_eff = DWELL_CAP;
        end else begin
            dwell_eff = dwell_raw;
        end
        cnt_inc = {{(CW-DWELL_BITS){1'b0}}, cnt} + {{(CW-1){1'b0}}, 1'b1};
        advance = (cnt_inc >= dwell_eff);
        n_cnt   = advance ? '0 : cnt_inc[DWELL_BITS-1:0];

        n_pair_pos    = pos;
        n_pair_rising = rising;
        n_phase       = phase;
        n_wave_idx    = idx;

        if (advance && !i_level) begin
            if (rising) begin
                if (pos + 3'd1 >= PAIR_POS_MAX || pos == LED_TOP) begin
                    n_pair_pos    = PAIR_POS_MAX;
                    n_pair_rising = 1'b0;
                end else begin
                    n_pair_pos = pos + 3'd1;
                end
            end else begin
                if (pos == LED_TOP) begin
                    n_pair_pos = PAIR_POS_MAX;
                end else if (pos <= 3'd1) begin
                    n_pair_pos    = '0;
                    n_pair_rising = 1'b1;
                end else begin
                    n_pair_pos = pos - 3'd1;
                end
            end
        end else if (advance) begin
            case (phase)
                PH_WAVE_UP: begin
                    if (idx == LED_TOP) begin
                        n_wave_idx = PAIR_POS_MAX;
                        n_phase    = PH_WAVE_DOWN;
                    end else begin
                        n_wave_idx = idx + 3'd1;
                    end
                end
                PH_WAVE_DOWN: begin
                    if (idx == '0) begin
                        n_phase = PH_EXPLODE;
                    end else begin
                        n_wave_idx = idx - 3'd1;
                    end
                end
                PH_EXPLODE: begin
                    if (idx >= 3'd3) begin
                        n_wave_idx = 3'd2;
                        n_phase    = PH_COLLAPSE;
                    end else begin
                        n_wave_idx = idx + 3'd1;
                    end
                end
                default: begin
                    if (idx == '0) begin
                        n_phase = PH_WAVE_UP;
                    end else begin
                        n_wave_idx = idx - 3'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= 1'b0;
            r_last        <= 1'b0;
            r_pair_pos    <= '0;
            r_pair_rising <= 1'b1;
            r_phase       <= PH_WAVE_UP;
            r_wave_idx    <= '0;
            r_cnt         <= '0;
        end else if (i_accept) begin
            r_seen        <= 1'b1;
            r_last        <= i_level;
            r_pair_pos    <= n_pair_pos;
            r_pair_rising <= n_pair_rising;
            r_phase       <= n_phase;
            r_wave_idx    <= n_wave_idx;
            r_cnt         <= n_cnt;
        end
    end

    // pair never reaches the top position
    a_pair_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair_pos <= PAIR_POS_MAX)
        else $error("ping-pong pair position out of range");

    // direction flips at the ends
    a_pair_dir_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pair_pos == PAIR_POS_MAX) |-> !r_pair_rising)
        and ((r_pair_pos == '0) |-> r_pair_rising))
        else $error("ping-pong direction wrong at an end");

    // explode and collapse only use distances zero to three
    a_explode_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXPLODE || r_phase == PH_COLLAPSE) |-> (r_wave_idx <= 3'd3))
        else $error("explode distance out of range");

endmodule

// File: design/led_pattern_sequencer_top.sv
// ----------------------------------------------------------------------------
// led_pattern_sequencer_top
// per-tick led chaser: ping-pong pair or wave / explode sequence
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  -------   ---------  ------------------  -------------------------
//  tick in   input      i_valid / o_stall   i_switch_level (1 bit)
//  led out   output     o_valid / i_stall   o_led_pattern (8 bits)
//  config    input      i_cfg_we            i_cfg_idx, i_cfg_wdata
//
//  one tick beat per clock while o_stall is low; its pattern sits in the
//  output register on the next cycle
//  the per-tick update is a few small counters and a shift, done between
//  the sequence state registers and the output register
//  o_stall is high only while the output register holds an untaken beat
//  and the consumer stalls; a free or draining register takes a new beat
//  reset (i_rst_n, synchronous, active low) loads dwell 150 for all modes
//  and makes the first tick restart both sequences
//
module led_pattern_sequencer_top
    import lps_pkg::*;
#(
    parameter int DWELL_BITS = DWELL_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tick input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_switch_level,
    // pattern output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [LED_W-1:0]     o_led_pattern,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cfg             cfg;
    logic             accept;
    logic [LED_W-1:0] pattern;

    logic             r_out_valid;
    logic [LED_W-1:0] r_led;

    // output register full and not being drained
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    lps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lps_core #(
        .DWELL_BITS (DWELL_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_level   (i_switch_level),
        .i_cfg     (cfg),
        .o_pattern (pattern)
    );

    // output register: valid is control, pattern is payload only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_led <= pattern;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_led_pattern = r_led;

    // every accepted tick gives a beat on the next cycle
    a_accept_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted tick produced no output beat");

    // no input taken while a pending beat is blocked
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !accept)
        else $error("pending beat overwritten");

    // a stalled beat keeps its valid and payload
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_led_pattern)))
        else $error("stalled beat changed");

endmodule
